>>> hw/rtl/obb_pkg.sv
package obb_pkg;

  // field widths on the channels
  localparam int CTR_FW = 63;
  localparam int ANG_FW = 48;
  localparam int EXT_FW = 60;

  // default component widths
  localparam int COORD_BITS_DEF  = 21;
  localparam int ANGLE_BITS_DEF  = 16;
  localparam int EXTENT_BITS_DEF = 20;

  // internal widths, sized for the widest components
  localparam int ANG_W = 16;
  localparam int TW    = COORD_BITS_DEF + 1;
  localparam int EW    = EXTENT_BITS_DEF;
  localparam int AXW   = 18;
  localparam int PW    = 2 * AXW;
  localparam int DOT_W = 2 * AXW + 2;
  localparam int TDOT_W = TW + AXW + 2;
  localparam int RAD_W = DOT_W + EW + 3;

  // lane counts
  localparam int NUM_ANG = 6;
  localparam int NUM_SC  = 2 * NUM_ANG;
  localparam int NUM_AX  = 15;
  localparam int NUM_FACE = 6;

  // fixed-point constants
  localparam int Q14_ONE      = 16384;
  localparam int Q14_HALF     = 8192;
  localparam int Q14_SHIFT    = 14;
  localparam int QUARTER_TURN = 16384;
  localparam int POLY_A       = 25736;
  localparam int POLY_B       = 10512;
  localparam int POLY_C       = 1160;
  localparam int EPS_Q28      = 268;
  localparam int LHS_SHIFT    = 15;

  typedef logic signed [AXW-1:0] q14_t;
  typedef q14_t vec3_t [3];
  typedef vec3_t mat3_t [3];
  typedef logic signed [TW-1:0] tco_t;
  typedef tco_t tvec_t [3];
  typedef logic [EW-1:0] ext_t;
  typedef logic signed [DOT_W-1:0] dot_t;
  typedef logic signed [TDOT_W-1:0] tdot_t;
  typedef logic [RAD_W-1:0] rad_t;

  // centre offset and extents that ride along the pipeline
  typedef struct {
    tvec_t t;
    ext_t  ea [3];
    ext_t  eb [3];
  } side_t;

  // q14 product, rounded half up
  function automatic q14_t mul14(input q14_t a, input q14_t b);
    logic signed [PW-1:0] p;
    p = PW'(a) * PW'(b) + PW'(Q14_HALF);
    return q14_t'(p >>> Q14_SHIFT);
  endfunction

  function automatic dot_t dot_ax(input vec3_t x, input vec3_t y);
    dot_t acc;
    acc = DOT_W'(x[0]) * DOT_W'(y[0]) + DOT_W'(x[1]) * DOT_W'(y[1])
        + DOT_W'(x[2]) * DOT_W'(y[2]);
    return acc;
  endfunction

  function automatic tdot_t dot_tl(input tvec_t t, input vec3_t l);
    tdot_t acc;
    acc = TDOT_W'(t[0]) * TDOT_W'(l[0]) + TDOT_W'(t[1]) * TDOT_W'(l[1])
        + TDOT_W'(t[2]) * TDOT_W'(l[2]);
    return acc;
  endfunction

  function automatic logic [DOT_W-1:0] mag_dot(input dot_t d);
    return d[DOT_W-1] ? DOT_W'(-d) : DOT_W'(d);
  endfunction

  function automatic logic [TDOT_W-1:0] mag_tdot(input tdot_t d);
    return d[TDOT_W-1] ? TDOT_W'(-d) : TDOT_W'(d);
  endfunction

endpackage

>>> hw/rtl/obb_if.sv
interface obb_in_if import obb_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CTR_FW-1:0] centre_a;
  logic [ANG_FW-1:0] angles_a;
  logic [EXT_FW-1:0] extent_a;
  logic [CTR_FW-1:0] centre_b;
  logic [ANG_FW-1:0] angles_b;
  logic [EXT_FW-1:0] extent_b;

  modport source (output valid, centre_a, angles_a, extent_a, centre_b, angles_b, extent_b,
                  input ready);
  modport sink (input valid, centre_a, angles_a, extent_a, centre_b, angles_b, extent_b,
                output ready);
endinterface

interface obb_out_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

>>> hw/rtl/obb_trig.sv
module obb_trig import obb_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ANG_W-1:0] ang [NUM_ANG],
  input  side_t            side_in,
  output logic             out_valid,
  input  logic             out_ready,
  output q14_t             sc [NUM_SC],
  output side_t            side_out
);

  localparam int NS = 4;

  logic [NS-1:0] v_r;
  logic [NS-1:0] en;
  side_t         side_r [NS];

  q14_t t_nxt   [NUM_SC];
  q14_t t2_nxt  [NUM_SC];
  logic neg_nxt [NUM_SC];

  q14_t s1_t_r [NUM_SC], s1_t2_r [NUM_SC];
  logic s1_neg_r [NUM_SC];
  q14_t s2_t_r [NUM_SC], s2_t2_r [NUM_SC], s2_inner_r [NUM_SC];
  logic s2_neg_r [NUM_SC];
  q14_t s3_t_r [NUM_SC], s3_mid_r [NUM_SC];
  logic s3_neg_r [NUM_SC];
  q14_t s4_sc_r [NUM_SC];

  // stall chain, a stage moves when it is empty or the next one moves
  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) en[k] = !v_r[k] || en[k+1];
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NS-1];
  assign side_out  = side_r[NS-1];
  assign sc        = s4_sc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NS; k++) if (en[k]) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) side_r[0] <= side_in;
    for (int k = 1; k < NS; k++) if (en[k]) side_r[k] <= side_r[k-1];
  end

  // quadrant fold, even lanes sine and odd lanes cosine
  always_comb begin
    logic [ANG_W-1:0] u;
    logic [13:0]      f;
    for (int l = 0; l < NUM_SC; l++) begin
      u = ang[l/2] + ((l % 2 == 1) ? ANG_W'(QUARTER_TURN) : '0);
      f = u[13:0];
      t_nxt[l]   = u[14] ? AXW'(Q14_ONE) - AXW'(f) : AXW'(f);
      neg_nxt[l] = u[15];
      t2_nxt[l]  = mul14(t_nxt[l], t_nxt[l]);
    end
  end

  // polynomial stages
  always_ff @(posedge clk) begin
    for (int l = 0; l < NUM_SC; l++) begin
      if (en[0]) begin
        s1_t_r[l]   <= t_nxt[l];
        s1_t2_r[l]  <= t2_nxt[l];
        s1_neg_r[l] <= neg_nxt[l];
      end
      if (en[1]) begin
        s2_t_r[l]     <= s1_t_r[l];
        s2_t2_r[l]    <= s1_t2_r[l];
        s2_neg_r[l]   <= s1_neg_r[l];
        s2_inner_r[l] <= AXW'(POLY_B) - mul14(AXW'(POLY_C), s1_t2_r[l]);
      end
      if (en[2]) begin
        s3_t_r[l]   <= s2_t_r[l];
        s3_neg_r[l] <= s2_neg_r[l];
        s3_mid_r[l] <= AXW'(POLY_A) - mul14(s2_t2_r[l], s2_inner_r[l]);
      end
      if (en[3]) begin
        s4_sc_r[l] <= s3_neg_r[l] ? -mul14(s3_t_r[l], s3_mid_r[l])
                                  : mul14(s3_t_r[l], s3_mid_r[l]);
      end
    end
  end

endmodule

>>> hw/rtl/obb_axes.sv
module obb_axes import obb_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  q14_t  sc [NUM_SC],
  input  side_t side_in,
  output logic  out_valid,
  input  logic  out_ready,
  output mat3_t box_ax [2],
  output side_t side_out
);

  localparam int NS = 2;

  logic [NS-1:0] v_r;
  logic [NS-1:0] en;
  side_t         side_r [NS];

  // first products per box
  q14_t crcy_r [2], srcp_r [2], crsy_r [2], srcy_r [2], crcp_r [2];
  q14_t srsy_r [2], cpsy_r [2], cpcy_r [2], psy_r [2], pcy_r [2];
  q14_t sp_r [2], sr_r [2], cr_r [2];
  mat3_t ax_r [2];

  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) en[k] = !v_r[k] || en[k+1];
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NS-1];
  assign side_out  = side_r[NS-1];
  assign box_ax    = ax_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NS; k++) if (en[k]) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) side_r[0] <= side_in;
    for (int k = 1; k < NS; k++) if (en[k]) side_r[k] <= side_r[k-1];
  end

  // lanes per box: sin pitch, cos pitch, sin yaw, cos yaw, sin roll, cos roll
  always_ff @(posedge clk) begin
    for (int b = 0; b < 2; b++) begin
      if (en[0]) begin
        crcy_r[b] <= mul14(sc[b*6+5], sc[b*6+3]);
        srcp_r[b] <= mul14(sc[b*6+4], sc[b*6+1]);
        crsy_r[b] <= mul14(sc[b*6+5], sc[b*6+2]);
        srcy_r[b] <= mul14(sc[b*6+4], sc[b*6+3]);
        crcp_r[b] <= mul14(sc[b*6+5], sc[b*6+1]);
        srsy_r[b] <= mul14(sc[b*6+4], sc[b*6+2]);
        cpsy_r[b] <= mul14(sc[b*6+1], sc[b*6+2]);
        cpcy_r[b] <= mul14(sc[b*6+1], sc[b*6+3]);
        psy_r[b]  <= mul14(sc[b*6+0], sc[b*6+2]);
        pcy_r[b]  <= mul14(sc[b*6+0], sc[b*6+3]);
        sp_r[b]   <= sc[b*6+0];
        sr_r[b]   <= sc[b*6+4];
        cr_r[b]   <= sc[b*6+5];
      end
      // rotation rows
      if (en[1]) begin
        ax_r[b][0][0] <= crcy_r[b] + mul14(sr_r[b], psy_r[b]);
        ax_r[b][0][1] <= srcp_r[b];
        ax_r[b][0][2] <= mul14(sr_r[b], pcy_r[b]) - crsy_r[b];
        ax_r[b][1][0] <= mul14(cr_r[b], psy_r[b]) - srcy_r[b];
        ax_r[b][1][1] <= crcp_r[b];
        ax_r[b][1][2] <= srsy_r[b] + mul14(cr_r[b], pcy_r[b]);
        ax_r[b][2][0] <= cpsy_r[b];
        ax_r[b][2][1] <= -sp_r[b];
        ax_r[b][2][2] <= cpcy_r[b];
      end
    end
  end

endmodule

>>> hw/rtl/obb_sat.sv
module obb_sat import obb_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  mat3_t box_ax [2],
  input  side_t side_in,
  output logic  out_valid,
  input  logic  out_ready,
  output logic  hit
);

  localparam int NS = 4;

  logic [NS-1:0] v_r;
  logic [NS-1:0] en;
  side_t         side_r [NS-2];

  vec3_t l_nxt [NUM_AX];
  vec3_t l_r   [NUM_AX];
  mat3_t a_r, b_r;

  dot_t  da_r [NUM_AX][3];
  dot_t  db_r [NUM_AX][3];
  tdot_t dt_r [NUM_AX];
  logic  skip2_r [NUM_AX];

  rad_t  pr_r [NUM_AX][6];
  rad_t  lhs_r [NUM_AX];
  logic  skip3_r [NUM_AX];

  logic  hit_nxt;
  logic  hit_r;

  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) en[k] = !v_r[k] || en[k+1];
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NS-1];
  assign hit       = hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NS; k++) if (en[k]) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) side_r[0] <= side_in;
    for (int k = 1; k < NS - 2; k++) if (en[k]) side_r[k] <= side_r[k-1];
  end

  // face axes, then cross axes of a row of a with a row of b
  always_comb begin
    for (int n = 0; n < 3; n++) begin
      l_nxt[n]     = box_ax[0][n];
      l_nxt[3 + n] = box_ax[1][n];
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        l_nxt[NUM_FACE + 3*i + j][0] = mul14(box_ax[0][i][1], box_ax[1][j][2])
                                     - mul14(box_ax[0][i][2], box_ax[1][j][1]);
        l_nxt[NUM_FACE + 3*i + j][1] = mul14(box_ax[0][i][2], box_ax[1][j][0])
                                     - mul14(box_ax[0][i][0], box_ax[1][j][2]);
        l_nxt[NUM_FACE + 3*i + j][2] = mul14(box_ax[0][i][0], box_ax[1][j][1])
                                     - mul14(box_ax[0][i][1], box_ax[1][j][0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      l_r <= l_nxt;
      a_r <= box_ax[0];
      b_r <= box_ax[1];
    end
  end

  // projections onto every axis, and the degenerate cross axis check
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int n = 0; n < NUM_AX; n++) begin
        for (int k = 0; k < 3; k++) begin
          da_r[n][k] <= dot_ax(l_r[n], a_r[k]);
          db_r[n][k] <= dot_ax(l_r[n], b_r[k]);
        end
        dt_r[n]    <= dot_tl(side_r[0].t, l_r[n]);
        skip2_r[n] <= (n >= NUM_FACE) && (dot_ax(l_r[n], l_r[n]) <= DOT_W'(EPS_Q28));
      end
    end
  end

  // radius terms scaled by the full extents
  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int n = 0; n < NUM_AX; n++) begin
        for (int k = 0; k < 3; k++) begin
          pr_r[n][k]     <= RAD_W'(mag_dot(da_r[n][k])) * RAD_W'(side_r[1].ea[k]);
          pr_r[n][3 + k] <= RAD_W'(mag_dot(db_r[n][k])) * RAD_W'(side_r[1].eb[k]);
        end
        lhs_r[n]   <= RAD_W'(mag_tdot(dt_r[n])) << LHS_SHIFT;
        skip3_r[n] <= skip2_r[n];
      end
    end
  end

  // overlap on every axis that is not skipped
  always_comb begin
    rad_t rhs;
    hit_nxt = 1'b1;
    for (int n = 0; n < NUM_AX; n++) begin
      rhs = pr_r[n][0] + pr_r[n][1] + pr_r[n][2] + pr_r[n][3] + pr_r[n][4] + pr_r[n][5];
      if (!skip3_r[n] && (lhs_r[n] > rhs)) hit_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) hit_r <= hit_nxt;
  end

endmodule

>>> hw/rtl/obb_overlap_test.sv
// Oriented box overlap test: each input beat carries two boxes (centre, pitch/yaw/roll,
// full extents) and yields one output beat whose hit bit is set when none of the
// fifteen separating axes (three face axes per box and nine cross axes) parts the
// boxes; cross axes of near-zero length are skipped. The datapath is a ten-stage
// pipeline: four stages of sine/cosine polynomial, two building the rotation rows,
// one forming the cross axes, and three for projection, radius and compare. A new
// pair is taken every cycle while the pipeline is not stalled. Back-pressure on the
// output stalls only the stages that are full, so bubbles are squeezed out.
module obb_overlap_test import obb_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int ANGLE_BITS  = ANGLE_BITS_DEF,
  parameter int EXTENT_BITS = EXTENT_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  obb_in_if.sink    in_box,
  obb_out_if.source out_res
);

  logic [ANG_W-1:0] ang [NUM_ANG];
  side_t            side0, side1, side2;
  q14_t             sc [NUM_SC];
  mat3_t            box_ax [2];
  logic             trig_valid, trig_ready;
  logic             axes_valid, axes_ready;

  // unpack the beat and form the centre offset
  always_comb begin
    logic signed [COORD_BITS-1:0] ca_v;
    logic signed [COORD_BITS-1:0] cb_v;
    for (int k = 0; k < 3; k++) begin
      ca_v = in_box.centre_a[k*COORD_BITS +: COORD_BITS];
      cb_v = in_box.centre_b[k*COORD_BITS +: COORD_BITS];
      side0.t[k]  = TW'(cb_v) - TW'(ca_v);
      side0.ea[k] = EW'(in_box.extent_a[k*EXTENT_BITS +: EXTENT_BITS]);
      side0.eb[k] = EW'(in_box.extent_b[k*EXTENT_BITS +: EXTENT_BITS]);
      ang[k]      = ANG_W'(in_box.angles_a[k*ANGLE_BITS +: ANGLE_BITS]) << (ANG_W - ANGLE_BITS);
      ang[3 + k]  = ANG_W'(in_box.angles_b[k*ANGLE_BITS +: ANGLE_BITS]) << (ANG_W - ANGLE_BITS);
    end
  end

  obb_trig u_trig (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_box.valid),
    .in_ready  (in_box.ready),
    .ang       (ang),
    .side_in   (side0),
    .out_valid (trig_valid),
    .out_ready (trig_ready),
    .sc        (sc),
    .side_out  (side1)
  );

  obb_axes u_axes (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (trig_valid),
    .in_ready  (trig_ready),
    .sc        (sc),
    .side_in   (side1),
    .out_valid (axes_valid),
    .out_ready (axes_ready),
    .box_ax    (box_ax),
    .side_out  (side2)
  );

  obb_sat u_sat (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (axes_valid),
    .in_ready  (axes_ready),
    .box_ax    (box_ax),
    .side_in   (side2),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .hit       (out_res.hit)
  );

endmodule
